FILE: rtl/core/fader_soft_takeover_macros.svh
// assertion macros for the fader soft-takeover block
// used by the controller and the datapath; no other dependencies
`ifndef FADER_SOFT_TAKEOVER_MACROS_SVH
`define FADER_SOFT_TAKEOVER_MACROS_SVH

// same-cycle implication
`define FST_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fst: same-cycle check failed");

// next-cycle implication
`define FST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fst: next-cycle check failed");

`endif

FILE: rtl/core/fst_pkg.sv
// shared types and constants for the fader soft-takeover block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fst_pkg;

  localparam int FADER_COUNT_DEF = 8;
  localparam int ADC_SHIFT       = 5;

  localparam logic [6:0] THRESH_RST = 7'd3;
  localparam logic [6:0] NOISE_RST  = 7'd2;

  // register word indexes
  localparam logic REG_THRESH = 1'b0;
  localparam logic REG_NOISE  = 1'b1;

  // result kinds
  localparam logic KIND_VOLUME = 1'b0;
  localparam logic KIND_NOTE   = 1'b1;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_TARGET = 2'd1,
    REQ_BANK   = 2'd2,
    REQ_MODE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_SAMP_NOTE,
    ST_SAMP_VOL,
    ST_TGT_SCAN,
    ST_TGT_NOTE,
    ST_CHANGE,
    ST_CLR_EMIT
  } state_e;

  typedef struct packed {
    logic load_req;
    logic idx_inc;
    logic upd_sample;
    logic write_last;
    logic set_pick;
    logic write_target;
    logic apply_change;
    logic emit;
    logic emit_kind;
    logic emit_needs;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic drop;
    logic picked;
    logic near_sample;
    logic match;
    logic near_target;
    logic same_cfg;
    logic idx_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/fst_ctrl.sv
// controller state machine of the fader soft-takeover block
// depends on fst_pkg and fader_soft_takeover_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "fader_soft_takeover_macros.svh"

module fst_ctrl
  import fst_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  input  wire logic [1:0] s_axis_tuser,
  output logic            s_axis_tready,
  input  wire sts_t       sts_i,
  output cmd_t            cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load_req = 1'b1;
          unique case (req_e'(s_axis_tuser)) inside
            REQ_SAMPLE:         state_d = ST_SAMPLE;
            REQ_TARGET:         state_d = ST_TGT_SCAN;
            REQ_BANK, REQ_MODE: state_d = ST_CHANGE;
          endcase
        end
      end
      ST_SAMPLE: begin
        if (!sts_i.in_range || sts_i.drop) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.upd_sample = 1'b1;
          if (sts_i.picked) begin
            state_d = ST_SAMP_VOL;
          end else if (sts_i.near_sample) begin
            cmd_o.set_pick = 1'b1;
            state_d        = ST_SAMP_NOTE;
          end else begin
            cmd_o.write_last = 1'b1;
            state_d          = ST_IDLE;
          end
        end
      end
      ST_SAMP_NOTE: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_kind = KIND_NOTE;
        if (sts_i.out_free) state_d = ST_SAMP_VOL;
      end
      ST_SAMP_VOL: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_kind = KIND_VOLUME;
        cmd_o.emit_last = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.write_last = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_TGT_SCAN: begin
        if (sts_i.match) begin
          cmd_o.write_target = 1'b1;
          if (!sts_i.picked && sts_i.near_target) begin
            cmd_o.set_pick = 1'b1;
            state_d        = ST_TGT_NOTE;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (sts_i.idx_last) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_TGT_NOTE: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_kind = KIND_NOTE;
        cmd_o.emit_last = 1'b1;
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      ST_CHANGE: begin
        if (sts_i.same_cfg) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.apply_change = 1'b1;
          state_d            = ST_CLR_EMIT;
        end
      end
      ST_CLR_EMIT: begin
        cmd_o.emit       = 1'b1;
        cmd_o.emit_kind  = KIND_NOTE;
        cmd_o.emit_needs = 1'b1;
        cmd_o.emit_last  = sts_i.idx_last;
        if (sts_i.out_free) begin
          if (sts_i.idx_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // the notification pass ends on the beat of the highest fader
  `FST_ASSERT_NEXT(a_clr_pass_ends, clk_i, rst_ni,
    (state_q == ST_CLR_EMIT && sts_i.idx_last && sts_i.out_free), (state_q == ST_IDLE))

endmodule

`default_nettype wire

FILE: rtl/core/fst_datapath.sv
// per-fader state, request latch and output register of the soft-takeover block
// depends on fst_pkg and fader_soft_takeover_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "fader_soft_takeover_macros.svh"

module fst_datapath
  import fst_pkg::*;
#(
  parameter int FADER_COUNT = FADER_COUNT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [6:0]  thresh_i,
  input  wire logic [6:0]  noise_i,
  input  wire logic [39:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,
  input  wire cmd_t        cmd_i,
  output sts_t             sts_o,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,
  output logic             m_axis_tuser,
  output logic             m_axis_tlast
);

  localparam int IW = (FADER_COUNT > 1) ? $clog2(FADER_COUNT) : 1;

  // latched request
  req_e        req_q;
  logic [2:0]  fader_q;
  logic [11:0] adc_q;
  logic [7:0]  trk_q;
  logic [6:0]  lvl_q;
  logic [7:0]  bank_q;
  logic [1:0]  mode_q;

  // per-fader and global state
  logic [7:0]             last_q  [FADER_COUNT];
  logic [6:0]             phys_q  [FADER_COUNT];
  logic [6:0]             tgt_q   [FADER_COUNT];
  logic [7:0]             track_q [FADER_COUNT];
  logic [FADER_COUNT-1:0] picked_q;
  logic [7:0]             bank_now_q;
  logic [1:0]             mode_now_q;
  logic [IW-1:0]          idx_q;

  // output register
  logic        ovalid_q;
  logic [39:0] odata_q;
  logic        okind_q;
  logic        olast_q;

  logic [6:0]        v;
  logic signed [9:0] nd;
  logic [9:0]        nd_abs;
  logic [7:0]        sd, td;
  logic              out_free;
  logic              load;
  logic [13:0]       v14;
  logic [6:0]        ovol;
  logic [39:0]       odata_d;

  assign v        = adc_q[11:ADC_SHIFT];
  assign out_free = !ovalid_q || m_axis_tready;
  assign load     = cmd_i.emit && out_free;

  always_comb begin
    nd     = $signed({3'b000, v}) - $signed({{2{last_q[idx_q][7]}}, last_q[idx_q]});
    nd_abs = nd[9] ? 10'(-nd) : 10'(nd);
    sd     = (v >= tgt_q[idx_q]) ? 8'(v - tgt_q[idx_q]) : 8'(tgt_q[idx_q] - v);
    td     = (phys_q[idx_q] >= lvl_q) ? 8'(phys_q[idx_q] - lvl_q) : 8'(lvl_q - phys_q[idx_q]);

    sts_o.in_range    = (32'(fader_q) < FADER_COUNT);
    sts_o.drop        = (nd_abs <= {3'b000, noise_i});
    sts_o.picked      = picked_q[idx_q];
    sts_o.near_sample = (sd <= {1'b0, thresh_i});
    sts_o.match       = (track_q[idx_q] == trk_q);
    sts_o.near_target = (td <= {1'b0, thresh_i});
    sts_o.same_cfg    = (req_q == REQ_BANK) ? (bank_q == bank_now_q) : (mode_q == mode_now_q);
    sts_o.idx_last    = (idx_q == IW'(FADER_COUNT - 1));
    sts_o.out_free    = out_free;
  end

  // volume is scaled to 14 bits as v * 129
  always_comb begin
    ovol    = (cmd_i.emit_kind == KIND_VOLUME) ? v : 7'd0;
    v14     = {ovol, 7'd0} + {7'd0, ovol};
    odata_d = {7'd0, v14[6:0], v14[13:7], ovol, cmd_i.emit_needs, track_q[idx_q], 3'(idx_q)};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q   <= req_e'(s_axis_tuser);
      fader_q <= s_axis_tdata[2:0];
      adc_q   <= s_axis_tdata[14:3];
      trk_q   <= s_axis_tdata[22:15];
      lvl_q   <= s_axis_tdata[29:23];
      bank_q  <= s_axis_tdata[37:30];
      mode_q  <= s_axis_tdata[39:38];
    end
    if (load) begin
      odata_q <= odata_d;
      okind_q <= cmd_i.emit_kind;
      olast_q <= cmd_i.emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FADER_COUNT; i++) begin
        last_q[i]  <= 8'hFF;
        phys_q[i]  <= 7'd0;
        tgt_q[i]   <= 7'd0;
        track_q[i] <= 8'(i);
      end
      picked_q   <= '0;
      bank_now_q <= 8'd0;
      mode_now_q <= 2'd0;
      idx_q      <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      if (cmd_i.load_req) begin
        // samples address their own fader, everything else scans from zero
        idx_q <= (req_e'(s_axis_tuser) == REQ_SAMPLE) ? IW'(s_axis_tdata[2:0]) : '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + IW'(1);
      end
      if (cmd_i.upd_sample)   phys_q[idx_q] <= v;
      if (cmd_i.write_last)   last_q[idx_q] <= {1'b0, v};
      if (cmd_i.write_target) tgt_q[idx_q]  <= lvl_q;
      if (cmd_i.set_pick)     picked_q[idx_q] <= 1'b1;
      if (cmd_i.apply_change) begin
        picked_q <= '0;
        if (req_q == REQ_BANK) begin
          bank_now_q <= bank_q;
          for (int i = 0; i < FADER_COUNT; i++) begin
            track_q[i] <= bank_q + 8'(i);
          end
        end else begin
          mode_now_q <= mode_q;
        end
      end
      if (load) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;

  // a volume beat only ever leaves for a picked-up fader
  `FST_ASSERT_NOW(a_vol_picked, clk_i, rst_ni,
    (load && cmd_i.emit_kind == KIND_VOLUME), (picked_q[idx_q]))
  // after the last needs-pickup beat no fader holds its pickup
  `FST_ASSERT_NEXT(a_clear_done, clk_i, rst_ni,
    (load && cmd_i.emit_last && cmd_i.emit_needs), (picked_q == '0))

endmodule

`default_nettype wire

FILE: rtl/core/fader_soft_takeover.sv
// top level of the fader soft-takeover block: register port, controller, datapath
// depends on fst_pkg, fst_ctrl and fst_datapath
//
//   port group   dir   tdata                  tuser         tlast
//   s_axis       in    request fields (40b)   req_type      -
//   m_axis       out   result fields (40b)    result_kind   last_of_run
//   apb          in    two 7-bit registers at byte 0 and 4
//
// one request at a time: a target update compares one fader per cycle,
// a bank or mode change sends one notification beat per cycle unless
// m_axis stalls.
// the output register frees the input side while a beat waits; a stalled
// m_axis holds the sequencer at its next emit. reset needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module fader_soft_takeover
  import fst_pkg::*;
#(
  parameter int FADER_COUNT = FADER_COUNT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // fader_index, adc_sample, track_number, remote_level, new_bank_offset, new_mode
  input  wire logic [39:0] s_axis_tdata,
  // req_type
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // fader_number, out_track, needs_pickup, volume_7bit, value_msb, value_lsb, 7 pad bits
  output logic [39:0]      m_axis_tdata,
  // result_kind
  output logic             m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [6:0] thresh_q, noise_q;
  logic       wr_en;
  cmd_t       cmd;
  sts_t       sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RST;
      noise_q  <= NOISE_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_THRESH: thresh_q <= pwdata[6:0];
        REG_NOISE:  noise_q  <= pwdata[6:0];
        default:    thresh_q <= thresh_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THRESH: prdata = {25'd0, thresh_q};
      REG_NOISE:  prdata = {25'd0, noise_q};
      default:    prdata = 32'd0;
    endcase
  end

  fst_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  fst_datapath #(
    .FADER_COUNT (FADER_COUNT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .thresh_i      (thresh_q),
    .noise_i       (noise_q),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb_fader_soft_takeover.sv
// self-checking testbench for the fader soft-takeover block: stream driver, stream monitor,
// register writes and a request-level model of the pickup logic
// depends on fst_pkg and the fader_soft_takeover rtl
`timescale 1ns / 1ps

module tb_fader_soft_takeover;
  import fst_pkg::*;

  localparam int FADER_SLOTS  = FADER_COUNT_DEF;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    req_e       kind;
    logic [2:0] fader;
    logic [11:0] adc;
    logic [7:0] track;
    logic [6:0] level;
    logic [7:0] bank;
    logic [1:0] mode;
  } fader_req_t;

  typedef struct {
    logic       kind;
    logic [2:0] fader;
    logic [7:0] track;
    logic       needs;
    logic [6:0] vol;
    logic [6:0] msb;
    logic [6:0] lsb;
    logic       last;
  } fader_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fader_soft_takeover #(.FADER_COUNT(FADER_SLOTS)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // model state
  logic [7:0] last_val  [FADER_SLOTS];
  logic [6:0] phys_val  [FADER_SLOTS];
  logic [6:0] tgt_val   [FADER_SLOTS];
  logic       picked    [FADER_SLOTS];
  logic [7:0] fader_trk [FADER_SLOTS];
  logic [7:0] bank_now;
  logic [1:0] mode_now;
  logic [6:0] thresh_now;
  logic [6:0] noise_now;

  // stimulus-side view of bank and targets, used to aim requests
  logic [7:0] gen_bank;
  logic [6:0] gen_tgt [FADER_SLOTS];

  fader_req_t  req_backlog[$];
  fader_req_t  cur_req;
  fader_beat_t fader_beats_due[$];
  int          errors = 0;
  int          cyc = 0;
  logic        calm;

  // long stretches with no idling on either side
  assign calm = (cyc % 1000) >= 600;

  function automatic int absdiff(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void push_beat(input logic kind, input int f, input logic needs,
                                    input logic [6:0] vol);
    fader_beat_t b;
    logic [13:0] v14;
    v14     = 14'(vol) * 14'd129;
    b.kind  = kind;
    b.fader = 3'(f);
    b.track = fader_trk[f];
    b.needs = needs;
    b.vol   = (kind == KIND_NOTE) ? 7'd0 : vol;
    b.msb   = (kind == KIND_NOTE) ? 7'd0 : v14[13:7];
    b.lsb   = (kind == KIND_NOTE) ? 7'd0 : v14[6:0];
    b.last  = 1'b0;
    fader_beats_due.push_back(b);
  endfunction

  function automatic void clear_pickups();
    for (int i = 0; i < FADER_SLOTS; i++) begin
      picked[i] = 1'b0;
      push_beat(KIND_NOTE, i, 1'b1, 7'd0);
    end
  endfunction

  function automatic void predict_fader_beats(input fader_req_t r);
    int         n_due;
    int         f;
    int         lv;
    logic [6:0] v;
    logic       found;
    n_due = fader_beats_due.size();
    case (r.kind)
      REQ_SAMPLE: begin
        f  = int'(r.fader);
        v  = 7'(r.adc >> ADC_SHIFT);
        lv = last_val[f][7] ? int'(last_val[f]) - 256 : int'(last_val[f]);
        if (f < FADER_SLOTS && absdiff(int'(v), lv) > int'(noise_now)) begin
          phys_val[f] = v;
          if (!picked[f] && absdiff(int'(v), int'(tgt_val[f])) <= int'(thresh_now)) begin
            picked[f] = 1'b1;
            push_beat(KIND_NOTE, f, 1'b0, 7'd0);
          end
          if (picked[f]) push_beat(KIND_VOLUME, f, 1'b0, v);
          last_val[f] = {1'b0, v};
        end
      end
      REQ_TARGET: begin
        found = 1'b0;
        for (int i = 0; i < FADER_SLOTS; i++) begin
          if (!found && fader_trk[i] == r.track) begin
            found = 1'b1;
            tgt_val[i] = r.level;
            if (!picked[i] &&
                absdiff(int'(phys_val[i]), int'(r.level)) <= int'(thresh_now)) begin
              picked[i] = 1'b1;
              push_beat(KIND_NOTE, i, 1'b0, 7'd0);
            end
          end
        end
      end
      REQ_BANK: begin
        if (r.bank != bank_now) begin
          bank_now = r.bank;
          for (int i = 0; i < FADER_SLOTS; i++) fader_trk[i] = r.bank + 8'(i);
          clear_pickups();
        end
      end
      default: begin
        if (r.mode != mode_now) begin
          mode_now = r.mode;
          clear_pickups();
        end
      end
    endcase
    if (fader_beats_due.size() > n_due) fader_beats_due[$].last = 1'b1;
  endfunction

  // driver: offers the next request when the slot is free, with random gaps outside calm stretches
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_fader_beats(cur_req);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_backlog.size() != 0 && (calm || $urandom_range(99) >= 14)) begin
          cur_req       <= req_backlog[0];
          s_axis_tdata  <= {req_backlog[0].mode, req_backlog[0].bank, req_backlog[0].level,
                            req_backlog[0].track, req_backlog[0].adc, req_backlog[0].fader};
          s_axis_tuser  <= req_backlog[0].kind;
          s_axis_tvalid <= 1'b1;
          void'(req_backlog.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // monitor: every output beat against the oldest expected beat
  always @(posedge clk_i) begin
    fader_beat_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (fader_beats_due.size() == 0) begin
          $error("unexpected beat: tdata %h tuser %0d", m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          e = fader_beats_due.pop_front();
          check_field("result_kind", e.kind, m_axis_tuser);
          check_field("fader_number", e.fader, m_axis_tdata[2:0]);
          check_field("out_track", e.track, m_axis_tdata[10:3]);
          check_field("needs_pickup", e.needs, m_axis_tdata[11]);
          check_field("volume_7bit", e.vol, m_axis_tdata[18:12]);
          check_field("value_msb", e.msb, m_axis_tdata[25:19]);
          check_field("value_lsb", e.lsb, m_axis_tdata[32:26]);
          check_field("last_of_run", e.last, m_axis_tlast);
        end
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic queue_req(input req_e kind, input int f, input int adc, input int trk,
                           input int lvl, input int bank, input int mode);
    fader_req_t r;
    int         idx;
    r.kind  = kind;
    r.fader = 3'(f);
    r.adc   = 12'(adc);
    r.track = 8'(trk);
    r.level = 7'(lvl);
    r.bank  = 8'(bank);
    r.mode  = 2'(mode);
    if (kind == REQ_BANK) gen_bank = r.bank;
    if (kind == REQ_TARGET) begin
      idx = int'(8'(r.track - gen_bank));
      if (idx < FADER_SLOTS) gen_tgt[idx] = r.level;
    end
    req_backlog.push_back(r);
  endtask

  task automatic queue_random(input int count);
    int roll;
    int f;
    int t;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      f    = $urandom_range(FADER_SLOTS - 1);
      if (roll < 55) begin
        if ($urandom_range(99) < 70) begin
          // aim near the current target so pickups actually happen
          t = int'(gen_tgt[f]) + int'($urandom_range(8)) - 4;
          if (t < 0) t = 0;
          if (t > 127) t = 127;
          queue_req(REQ_SAMPLE, f, (t << 5) | $urandom_range(31), $urandom, $urandom,
                    $urandom, $urandom);
        end else begin
          queue_req(REQ_SAMPLE, f, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
      end else if (roll < 75) begin
        if ($urandom_range(99) < 85) t = int'(gen_bank) + f;
        else t = $urandom_range(255);
        queue_req(REQ_TARGET, $urandom, $urandom, t, $urandom, $urandom, $urandom);
      end else if (roll < 87) begin
        if ($urandom_range(3) == 0) t = gen_bank;
        else t = $urandom_range(255);
        queue_req(REQ_BANK, $urandom, $urandom, $urandom, $urandom, t, $urandom);
      end else begin
        queue_req(REQ_MODE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic wait_quiet();
    while (req_backlog.size() != 0 || s_axis_tvalid || fader_beats_due.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic reg_idx, input logic [6:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {25'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_THRESH) thresh_now = val;
    else noise_now = val;
  endtask

  initial begin
    logic [6:0] thr_set [7];
    logic [6:0] nse_set [7];
    for (int i = 0; i < FADER_SLOTS; i++) begin
      last_val[i]  = 8'hFF;
      phys_val[i]  = '0;
      tgt_val[i]   = '0;
      picked[i]    = 1'b0;
      fader_trk[i] = 8'(i);
      gen_tgt[i]   = '0;
    end
    bank_now   = '0;
    mode_now   = '0;
    gen_bank   = '0;
    thresh_now = THRESH_RST;
    noise_now  = NOISE_RST;
    thr_set = '{THRESH_RST, 7'd0, 7'd127, 7'd127, 7'd0, 7'($urandom_range(1, 10)),
                7'($urandom_range(127))};
    nse_set = '{NOISE_RST, 7'd0, 7'd127, 7'd0, 7'd127, 7'($urandom_range(5)),
                7'($urandom_range(127))};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int p = 0; p < 7; p++) begin
      wait_quiet();
      reg_write(REG_THRESH, thr_set[p]);
      reg_write(REG_NOISE, nse_set[p]);
      if (p == 0) begin
        // values 0 and 1 fall inside the noise band of the reset last value
        queue_req(REQ_SAMPLE, 0, 0, 0, 0, 0, 0);
        queue_req(REQ_SAMPLE, 0, 63, 255, 127, 255, 3);
        // far from target: remembered but silent
        queue_req(REQ_SAMPLE, 0, 4095, 0, 0, 0, 0);
        // within threshold: pickup note then volume
        queue_req(REQ_SAMPLE, 1, 64, 0, 0, 0, 0);
        queue_req(REQ_SAMPLE, 1, 4095, 0, 0, 0, 0);
        // same value again, dropped as noise
        queue_req(REQ_SAMPLE, 1, 4064, 0, 0, 0, 0);
        // target reaches a parked fader: automatic pickup
        queue_req(REQ_TARGET, 0, 0, 0, 127, 0, 0);
        queue_req(REQ_TARGET, 0, 0, 200, 5, 0, 0);
        queue_req(REQ_SAMPLE, 0, 0, 0, 0, 0, 0);
        queue_req(REQ_SAMPLE, 7, 100, 0, 0, 0, 0);
        queue_req(REQ_TARGET, 0, 0, 7, 3, 0, 0);
        queue_req(REQ_BANK, 0, 0, 0, 0, 8, 0);
        queue_req(REQ_BANK, 0, 0, 0, 0, 8, 0);
        // bank near the top: tracks wrap past 255
        queue_req(REQ_BANK, 0, 0, 0, 0, 255, 0);
        queue_req(REQ_TARGET, 0, 0, 255, 0, 0, 0);
        queue_req(REQ_TARGET, 0, 0, 6, 127, 0, 0);
        queue_req(REQ_SAMPLE, 7, 4095, 0, 0, 0, 0);
        queue_req(REQ_SAMPLE, 0, 31, 0, 0, 0, 0);
        queue_req(REQ_MODE, 0, 0, 0, 0, 0, 3);
        queue_req(REQ_MODE, 0, 0, 0, 0, 0, 3);
        queue_req(REQ_MODE, 0, 0, 0, 0, 0, 0);
        queue_req(REQ_SAMPLE, 3, 2048, 0, 0, 0, 0);
        queue_req(REQ_BANK, 0, 0, 0, 0, 0, 0);
      end
      queue_random(27);
    end

    wait_quiet();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/fst_pkg.sv
rtl/core/fst_ctrl.sv
rtl/core/fst_datapath.sv
rtl/core/fader_soft_takeover.sv
tb/sv/tb_fader_soft_takeover.sv
